/* sv/kest_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kest_pkg
// Shared types, codes and helpers for the key event state tracker.
// ----------------------------------------------------------------------------
package kest_pkg;

  localparam int NUM_KEYS_DEF  = 256;
  localparam int TIME_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ST_PRESS   = 3'd0,
    ST_RELEASE = 3'd1,
    ST_HELD    = 3'd2,
    ST_OPEN    = 3'd3,
    ST_DBL     = 3'd4
  } key_state_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DOWN  = 2'd1,
    OP_UP    = 2'd2,
    OP_OTHER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_TICK_STEP = 2'd0,
    CFG_DC_WINDOW = 2'd1
  } cfg_index_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SWEEP,
    FSM_FINISH
  } fsm_t;

  localparam logic [4:0] BIT_PRESS      = 5'd1;
  localparam logic [4:0] BIT_RELEASE    = 5'd2;
  localparam logic [4:0] BIT_HELD       = 5'd4;
  localparam logic [4:0] BIT_OPEN       = 5'd8;
  localparam logic [4:0] BIT_DBL        = 5'd16;
  localparam logic [4:0] STATE_BITS_ALL = 5'd31;

  localparam int K_LSHIFT = 215;
  localparam int K_RSHIFT = 216;
  localparam int K_LCTRL  = 217;
  localparam int K_RCTRL  = 218;
  localparam int K_ALT    = 219;
  localparam int K_ALTGR  = 220;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  key_state;
    logic        key_is_down;
    logic [15:0] held_time;
    logic [4:0]  any_shift_mask;
    logic [4:0]  any_ctrl_mask;
    logic [4:0]  any_alt_mask;
    logic [4:0]  no_mod_mask;
  } out_word_t;

  // per-sweep control seen by the entry update
  typedef struct packed {
    logic [1:0]  op;
    logic        hit;
    logic [7:0]  tick_step;
    logic [15:0] window;
  } upd_ctrl_t;

  function automatic logic [4:0] state_bits(input logic [2:0] st);
    state_bits = (5'd1 << st) & STATE_BITS_ALL;
  endfunction

  function automatic logic [4:0] age_mask(input logic [4:0] m);
    if ((m & (BIT_PRESS | BIT_DBL)) != 5'd0) age_mask = BIT_HELD;
    else if (m == BIT_RELEASE)               age_mask = BIT_OPEN;
    else                                     age_mask = m;
  endfunction

endpackage
`default_nettype wire

/* sv/key_event_state_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_state_tracker
// Per-key press/hold/release/double-click tracker over a key-state memory.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | word
// in      | in  | in_valid/in_stall  | in_data   (operation, key_code)
// out     | out | out_valid/out_stall| out_data  (state, down, held, masks)
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// After reset a clearing pass writes every entry while the input is stalled.
// Each event sweeps the whole key memory: one entry read per cycle, written
// back in the following cycle. The input stays stalled until the result is
// registered, so a new word is taken only once the last one is through. The
// key memory has one read and one write port. A stalled result holds the next
// sweep's finish; config is always ready.
// ----------------------------------------------------------------------------
module key_event_state_tracker #(
  parameter int NUM_KEYS  = kest_pkg::NUM_KEYS_DEF,
  parameter int TIME_BITS = kest_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  kest_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output kest_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import kest_pkg::*;

  localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int EW = 4 + 2 * TIME_BITS;
  localparam logic [IW-1:0] LAST = IW'(NUM_KEYS - 1);

  // entry layout: {state, down, held, time since press}
  logic [EW-1:0] mem [NUM_KEYS];
  logic [EW-1:0] mem_q;

  fsm_t fsm, fsm_next;

  logic [7:0]  tick_step;
  logic [15:0] dc_window;

  in_word_t      ev;          // event being swept
  logic [IW-1:0] rd_idx;
  logic          rd_on;       // read issue active
  logic [IW-1:0] wr_idx;
  logic          wr_on;       // mem_q holds entry wr_idx

  // captured result of the addressed key and modifier bits
  logic [2:0]           res_st;
  logic                 res_down;
  logic [TIME_BITS-1:0] res_held;
  logic [4:0]           mod_bits [6];

  logic [4:0] m_shift, m_ctrl, m_alt, m_none;

  assign cfg_ready = 1'b1;
  assign in_stall  = (fsm != FSM_IDLE);

  // ---- entry update on the read data ----
  upd_ctrl_t            ctrl;
  logic [2:0]           u_st;
  logic                 u_down;
  logic [TIME_BITS-1:0] u_held, u_tsp;

  assign ctrl.op        = ev.operation;
  assign ctrl.hit       = (32'(wr_idx) == 32'(ev.key_code));
  assign ctrl.tick_step = tick_step;
  assign ctrl.window    = dc_window;

  kest_entry_update #(.TIME_BITS(TIME_BITS)) u_upd (
    .ctrl     (ctrl),
    .st_in    (mem_q[EW-1 -: 3]),
    .down_in  (mem_q[2*TIME_BITS]),
    .held_in  (mem_q[2*TIME_BITS-1 -: TIME_BITS]),
    .tsp_in   (mem_q[TIME_BITS-1:0]),
    .st_out   (u_st),
    .down_out (u_down),
    .held_out (u_held),
    .tsp_out  (u_tsp)
  );

  logic last_wr;
  assign last_wr = wr_on && (wr_idx == LAST) && !rd_on;

  logic key_op_hit;
  assign key_op_hit = (ev.operation == OP_DOWN || ev.operation == OP_UP) &&
                      (32'(ev.key_code) < NUM_KEYS);

  // ---- next state ----
  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      FSM_CLEAR:  if (rd_idx == LAST) fsm_next = FSM_IDLE;
      FSM_IDLE:   if (in_valid) fsm_next = FSM_SWEEP;
      FSM_SWEEP:  if (last_wr) fsm_next = FSM_FINISH;
      FSM_FINISH: if (!out_valid || !out_stall) fsm_next = FSM_IDLE;
      default:    fsm_next = FSM_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) fsm <= FSM_CLEAR;
    else     fsm <= fsm_next;
  end

  // ---- config registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= 8'd16;
      dc_window <= 16'd500;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TICK_STEP: tick_step <= cfg_data[7:0];
        CFG_DC_WINDOW: dc_window <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- memory: one read, one write per cycle ----
  always_ff @(posedge clk) begin
    if (fsm == FSM_CLEAR)
      mem[rd_idx] <= {ST_OPEN, 1'b0, {TIME_BITS{1'b0}}, {TIME_BITS{1'b1}}};
    else if (wr_on)
      mem[wr_idx] <= {u_st, u_down, u_held, u_tsp};
    mem_q <= mem[rd_idx];
  end

  // ---- sweep sequencing ----
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      rd_on  <= 1'b0;
      wr_on  <= 1'b0;
    end else begin
      wr_on <= rd_on;
      unique case (fsm)
        FSM_CLEAR: rd_idx <= (rd_idx == LAST) ? '0 : rd_idx + 1'b1;
        FSM_IDLE: begin
          if (in_valid) rd_on <= 1'b1;
          rd_idx <= '0;
        end
        FSM_SWEEP: begin
          if (rd_on) begin
            if (rd_idx == LAST) rd_on <= 1'b0;
            else                rd_idx <= rd_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload side of the sweep
  always_ff @(posedge clk) begin
    if (fsm == FSM_IDLE && in_valid) begin
      ev       <= in_data;
      res_st   <= ST_OPEN;
      res_down <= 1'b0;
      res_held <= '0;
      for (int j = 0; j < 6; j++) mod_bits[j] <= BIT_OPEN;
    end
    if (rd_on) wr_idx <= rd_idx;
    if (wr_on) begin
      if (ctrl.hit) begin
        res_st   <= u_st;
        res_down <= u_down;
        res_held <= u_held;
      end
      if (32'(wr_idx) == K_LSHIFT) mod_bits[0] <= state_bits(u_st);
      if (32'(wr_idx) == K_RSHIFT) mod_bits[1] <= state_bits(u_st);
      if (32'(wr_idx) == K_LCTRL)  mod_bits[2] <= state_bits(u_st);
      if (32'(wr_idx) == K_RCTRL)  mod_bits[3] <= state_bits(u_st);
      if (32'(wr_idx) == K_ALT)    mod_bits[4] <= state_bits(u_st);
      if (32'(wr_idx) == K_ALTGR)  mod_bits[5] <= state_bits(u_st);
    end
  end

  // ---- modifier masks and result register ----
  logic [4:0] as_n, ac_n, aa_n;
  logic [31:0] held_ext;

  always_comb begin
    as_n = mod_bits[0] | mod_bits[1];
    ac_n = mod_bits[2] | mod_bits[3];
    aa_n = mod_bits[4] | mod_bits[5];
    held_ext = 32'(res_held);
  end

  logic finish_go;
  assign finish_go = (fsm == FSM_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_shift <= BIT_OPEN;
      m_ctrl  <= BIT_OPEN;
      m_alt   <= BIT_OPEN;
      m_none  <= BIT_OPEN;
    end else if (finish_go) begin
      if (key_op_hit) begin
        m_shift <= as_n;
        m_ctrl  <= ac_n;
        m_alt   <= aa_n;
        m_none  <= ~as_n & ~ac_n & ~aa_n & STATE_BITS_ALL;
      end else begin
        m_shift <= age_mask(m_shift);
        m_ctrl  <= age_mask(m_ctrl);
        m_alt   <= age_mask(m_alt);
        m_none  <= age_mask(m_none);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (finish_go) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_data.key_state   <= res_st;
      out_data.key_is_down <= res_down;
      out_data.held_time   <= (held_ext > 32'hFFFF) ? 16'hFFFF : held_ext[15:0];
      if (key_op_hit) begin
        out_data.any_shift_mask <= as_n;
        out_data.any_ctrl_mask  <= ac_n;
        out_data.any_alt_mask   <= aa_n;
        out_data.no_mod_mask    <= ~as_n & ~ac_n & ~aa_n & STATE_BITS_ALL;
      end else begin
        out_data.any_shift_mask <= age_mask(m_shift);
        out_data.any_ctrl_mask  <= age_mask(m_ctrl);
        out_data.any_alt_mask   <= age_mask(m_alt);
        out_data.no_mod_mask    <= age_mask(m_none);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/kest_entry_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kest_entry_update
// Read-modify step for one key entry: aging, tick timers, key down/up.
// ----------------------------------------------------------------------------
module kest_entry_update #(
  parameter int TIME_BITS = kest_pkg::TIME_BITS_DEF
) (
  input  kest_pkg::upd_ctrl_t   ctrl,
  input  logic [2:0]            st_in,
  input  logic                  down_in,
  input  logic [TIME_BITS-1:0]  held_in,
  input  logic [TIME_BITS-1:0]  tsp_in,
  output logic [2:0]            st_out,
  output logic                  down_out,
  output logic [TIME_BITS-1:0]  held_out,
  output logic [TIME_BITS-1:0]  tsp_out
);
  import kest_pkg::*;

  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [7:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    sat_add = s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  logic [2:0] aged;

  always_comb begin
    if (st_in == ST_PRESS || st_in == ST_DBL) aged = ST_HELD;
    else if (st_in == ST_RELEASE)             aged = ST_OPEN;
    else                                      aged = st_in;

    st_out   = aged;
    down_out = down_in;
    held_out = held_in;
    tsp_out  = tsp_in;

    unique case (ctrl.op)
      OP_TICK: begin
        if (aged == ST_HELD) held_out = sat_add(held_in, ctrl.tick_step);
        tsp_out = sat_add(tsp_in, ctrl.tick_step);
      end
      OP_DOWN: begin
        if (ctrl.hit) begin
          st_out   = (32'(tsp_in) < 32'(ctrl.window)) ? ST_DBL : ST_PRESS;
          tsp_out  = '0;
          down_out = 1'b1;
        end
      end
      OP_UP: begin
        if (ctrl.hit) begin
          st_out   = ST_RELEASE;
          down_out = 1'b0;
          held_out = '0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
